>>> rtl/biquad_iir_filter_defines.svh
// Assertion macros shared by the biquad RTL.
`ifndef BIQUAD_IIR_FILTER_DEFINES_SVH
`define BIQUAD_IIR_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clock
`define BIQ_ASSERT_IMP(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("biquad assertion failed");

// next-cycle implication, sampled on clock
`define BIQ_ASSERT_NXT(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("biquad assertion failed");

`endif

>>> rtl/biq_pkg.sv
package biq_pkg;

   localparam int CHANNELS_DEF    = 8;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int GAIN_BITS       = 24;
   localparam int GAIN_FRAC       = 20;
   localparam int CHAN_BITS       = 3;
   localparam int CSR_INDEX_BITS  = 3;

   typedef logic signed [GAIN_BITS-1:0] gain_type;

   localparam gain_type FF_GAIN_0_RESET = gain_type'(1 << GAIN_FRAC);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FF_GAIN_0,
      CSR_FF_GAIN_1,
      CSR_FF_GAIN_2,
      CSR_FB_GAIN_1,
      CSR_FB_GAIN_2
   } csr_index_type;

   typedef struct packed {
      gain_type ff0;
      gain_type ff1;
      gain_type ff2;
      gain_type fb1;
      gain_type fb2;
   } gains_type;

   typedef struct packed {
      logic update;
      logic clear;
   } hist_ctl_type;

endpackage

>>> rtl/biquad_iir_filter.sv
// Second-order direct form I IIR filter with up to CHANNELS independent
// histories, one signed Q1.(SAMPLE_BITS-1) sample per transfer. Sustained rate
// is one sample per clock while rsp_tready stays high, also for the same
// channel back to back. A sample is held in the input register and its result
// in the output register, which drives rsp_tvalid; between the two lies the
// single multiply-accumulate pass (five parallel products, one sum,
// round and saturate). A channel's history is written as its item moves into
// the output register, so the next item sees it in the following cycle.
// Coefficients are Q4.20, already divided by a0; the user must write them
// through the csr port only while the block is idle, which the block does not
// enforce. Any accepted coefficient write clears all history in the same cycle.
// A channel number at or above CHANNELS returns zero and leaves history as is.
module biquad_iir_filter
   import biq_pkg::*;
#(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,  // sample_in
   input  logic [CHAN_BITS-1:0]       req_tuser,           // channel_in
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,  // sample_out
   output logic [CHAN_BITS-1:0]       rsp_tuser,           // channel_out
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [GAIN_BITS-1:0]       csr_wdata
);

`include "biquad_iir_filter_defines.svh"

   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [CHAN_BITS-1:0]   s1_chan_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic [CHAN_BITS-1:0]   rsp_chan_ff;
   gains_type              gains_ff, gains_in;

   logic                   req_fire;
   logic                   advance;
   logic                   s1_move;
   logic                   chan_ok;
   logic                   csr_hit;
   hist_ctl_type           hist_ctl;
   logic [SAMPLE_BITS-1:0] h_x1, h_x2, h_y1, h_y2;
   logic [SAMPLE_BITS-1:0] mac_y;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign chan_ok    = 32'(s1_chan_ff) < CHANNELS;

   assign s1_valid_in   = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in  = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_sample_in = chan_ok ? mac_y : '0;

   always_comb begin
      gains_in = gains_ff;
      csr_hit  = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FF_GAIN_0: begin
               gains_in.ff0 = csr_wdata;
               csr_hit      = 1'b1;
            end
            CSR_FF_GAIN_1: begin
               gains_in.ff1 = csr_wdata;
               csr_hit      = 1'b1;
            end
            CSR_FF_GAIN_2: begin
               gains_in.ff2 = csr_wdata;
               csr_hit      = 1'b1;
            end
            CSR_FB_GAIN_1: begin
               gains_in.fb1 = csr_wdata;
               csr_hit      = 1'b1;
            end
            CSR_FB_GAIN_2: begin
               gains_in.fb2 = csr_wdata;
               csr_hit      = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   assign hist_ctl = '{update: s1_move && chan_ok, clear: csr_hit};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gains_ff     <= '{ff0: FF_GAIN_0_RESET, default: '0};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         gains_ff     <= gains_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
         s1_chan_ff   <= req_tuser;
      end
      if (s1_move) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_chan_ff   <= s1_chan_ff;
      end
   end

   biq_hist #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W)
   ) u_hist (
      .clock  (clock),
      .reset  (reset),
      .ctl    (hist_ctl),
      .rd_idx (IDX_W'(s1_chan_ff)),
      .x_new  (s1_sample_ff),
      .y_new  (mac_y),
      .x1     (h_x1),
      .x2     (h_x2),
      .y1     (h_y1),
      .y2     (h_y2)
   );

   biq_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .gains (gains_ff),
      .x0    (s1_sample_ff),
      .x1    (h_x1),
      .x2    (h_x2),
      .y1    (h_y1),
      .y2    (h_y2),
      .y0    (mac_y)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_sample_ff);
   assign rsp_tuser  = rsp_chan_ff;

   `BIQ_ASSERT_IMP(a_backpressure, reset, s1_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready)
   `BIQ_ASSERT_NXT(a_move_to_rsp, reset, s1_move, rsp_valid_ff && rsp_chan_ff == $past(s1_chan_ff))
   `BIQ_ASSERT_NXT(a_bad_chan_zero, reset, s1_move && !chan_ok, rsp_sample_ff == '0)

endmodule

>>> rtl/biq_mac.sv
module biq_mac
   import biq_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  gains_type               gains,
   input  logic [SAMPLE_BITS-1:0]  x0,
   input  logic [SAMPLE_BITS-1:0]  x1,
   input  logic [SAMPLE_BITS-1:0]  x2,
   input  logic [SAMPLE_BITS-1:0]  y1,
   input  logic [SAMPLE_BITS-1:0]  y2,
   output logic [SAMPLE_BITS-1:0]  y0
);

   localparam int PROD_W = SAMPLE_BITS + GAIN_BITS;
   localparam int ACC_W  = PROD_W + 3;
   localparam int Q_W    = ACC_W - GAIN_FRAC;

   localparam logic signed [Q_W-1:0] Q_MAX =
      {{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN =
      {{(Q_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [Q_W-1:0]    q;

   assign p0 = $signed(x0) * $signed(gains.ff0);
   assign p1 = $signed(x1) * $signed(gains.ff1);
   assign p2 = $signed(x2) * $signed(gains.ff2);
   assign p3 = $signed(y1) * $signed(gains.fb1);
   assign p4 = $signed(y2) * $signed(gains.fb2);

   assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4);

   // round half up, then floor by the gain fraction
   assign rnd = acc + $signed(ACC_W'(1) << (GAIN_FRAC - 1));
   assign q   = $signed(rnd[ACC_W-1:GAIN_FRAC]);

   always_comb begin
      if (q > Q_MAX) begin
         y0 = Q_MAX[SAMPLE_BITS-1:0];
      end else if (q < Q_MIN) begin
         y0 = Q_MIN[SAMPLE_BITS-1:0];
      end else begin
         y0 = q[SAMPLE_BITS-1:0];
      end
   end

endmodule

>>> rtl/biq_hist.sv
module biq_hist
   import biq_pkg::*;
#(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int IDX_W       = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hist_ctl_type           ctl,
   input  logic [IDX_W-1:0]       rd_idx,
   input  logic [SAMPLE_BITS-1:0] x_new,
   input  logic [SAMPLE_BITS-1:0] y_new,
   output logic [SAMPLE_BITS-1:0] x1,
   output logic [SAMPLE_BITS-1:0] x2,
   output logic [SAMPLE_BITS-1:0] y1,
   output logic [SAMPLE_BITS-1:0] y2
);

`include "biquad_iir_filter_defines.svh"

   logic [SAMPLE_BITS-1:0] x1_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] x2_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] y1_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] y2_ff [CHANNELS];

   assign x1 = x1_ff[rd_idx];
   assign x2 = x2_ff[rd_idx];
   assign y1 = y1_ff[rd_idx];
   assign y2 = y2_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int c = 0; c < CHANNELS; c++) begin
            x1_ff[c] <= '0;
            x2_ff[c] <= '0;
            y1_ff[c] <= '0;
            y2_ff[c] <= '0;
         end
      end else if (ctl.update) begin
         x2_ff[rd_idx] <= x1_ff[rd_idx];
         x1_ff[rd_idx] <= x_new;
         y2_ff[rd_idx] <= y1_ff[rd_idx];
         y1_ff[rd_idx] <= y_new;
      end
   end

   `BIQ_ASSERT_NXT(a_hist_shift, reset, ctl.update && !ctl.clear, y2_ff[$past(rd_idx)] == $past(y1_ff[rd_idx]) && y1_ff[$past(rd_idx)] == $past(y_new))
   `BIQ_ASSERT_NXT(a_hist_clear, reset, ctl.clear, y1_ff[0] == '0 && x1_ff[0] == '0 && y2_ff[0] == '0)

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import biq_pkg::*;

   localparam int CH_COUNT     = CHANNELS_DEF;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 200;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 3000;
   localparam int SETTLE       = 4;

   localparam logic [23:0] SMAX = 24'h7FFFFF;
   localparam logic [23:0] SMIN = 24'h800000;
   localparam longint SAT_HI = (longint'(1) <<< 23) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   // writes to indices past the gain registers are ignored by the block
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [CSR_INDEX_BITS-1:0] IDX_NONE     = 3'd0;

   localparam logic ROW_SAMPLE = 1'b0;
   localparam logic ROW_CSR    = 1'b1;
   localparam logic NO_CHECK   = 1'b0;
   localparam logic CHECKED    = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [2:0]  idx;
      logic [23:0] val;
      logic [2:0]  chan;
      logic        typed;
      logic [23:0] want;
   } dir_row_type;

   typedef struct packed {
      logic [23:0] sample;
      logic [2:0]  chan;
   } filt_out_type;

   localparam int N_DIR = 28;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [23:0]               req_tdata;   // sample_in
   logic [CHAN_BITS-1:0]      req_tuser;   // channel_in
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [23:0]               rsp_tdata;   // sample_out
   logic [CHAN_BITS-1:0]      rsp_tuser;   // channel_out
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [GAIN_BITS-1:0]      csr_wdata;

   gain_type           gain_val [0:4];
   logic signed [23:0] hist_x1 [0:CH_COUNT-1];
   logic signed [23:0] hist_x2 [0:CH_COUNT-1];
   logic signed [23:0] hist_y1 [0:CH_COUNT-1];
   logic signed [23:0] hist_y2 [0:CH_COUNT-1];

   filt_out_type pending_out[$];
   int           errors;
   int           results_seen;

   dir_row_type plan [0:N_DIR-1] = '{
      '{ROW_SAMPLE, IDX_NONE, 24'h000000, 3'd0, CHECKED, 24'h000000},
      '{ROW_SAMPLE, IDX_NONE, SMAX,       3'd1, CHECKED, SMAX},
      '{ROW_SAMPLE, IDX_NONE, SMIN,       3'd2, CHECKED, SMIN},
      '{ROW_SAMPLE, IDX_NONE, 24'h000001, 3'd3, CHECKED, 24'h000001},
      '{ROW_SAMPLE, IDX_NONE, 24'hFFFFFF, 3'd4, CHECKED, 24'hFFFFFF},
      '{ROW_SAMPLE, IDX_NONE, 24'h555555, 3'd5, CHECKED, 24'h555555},
      '{ROW_SAMPLE, IDX_NONE, 24'hAAAAAA, 3'd6, CHECKED, 24'hAAAAAA},
      '{ROW_SAMPLE, IDX_NONE, 24'h003039, 3'd7, CHECKED, 24'h003039},
      '{ROW_CSR, CSR_FF_GAIN_0, SMAX, 3'd0, NO_CHECK, 24'h0},
      '{ROW_SAMPLE, IDX_NONE, SMAX,       3'd0, CHECKED, SMAX},
      '{ROW_SAMPLE, IDX_NONE, SMIN,       3'd1, CHECKED, SMIN},
      '{ROW_CSR, CSR_FF_GAIN_0, SMIN, 3'd0, NO_CHECK, 24'h0},
      '{ROW_SAMPLE, IDX_NONE, SMIN,       3'd2, CHECKED, SMAX},
      '{ROW_SAMPLE, IDX_NONE, SMAX,       3'd3, CHECKED, SMIN},
      '{ROW_SAMPLE, IDX_NONE, 24'h000000, 3'd4, CHECKED, 24'h000000},
      '{ROW_CSR, CSR_FF_GAIN_0, 24'h080000, 3'd0, NO_CHECK, 24'h0},
      '{ROW_CSR, CSR_FF_GAIN_1, 24'h040000, 3'd0, NO_CHECK, 24'h0},
      '{ROW_CSR, CSR_FF_GAIN_2, 24'hFE0000, 3'd0, NO_CHECK, 24'h0},
      '{ROW_CSR, CSR_FB_GAIN_1, 24'hE80000, 3'd0, NO_CHECK, 24'h0},
      '{ROW_CSR, CSR_FB_GAIN_2, 24'h0B3333, 3'd0, NO_CHECK, 24'h0},
      '{ROW_SAMPLE, IDX_NONE, SMAX,       3'd0, NO_CHECK, 24'h0},
      '{ROW_SAMPLE, IDX_NONE, 24'h000000, 3'd0, NO_CHECK, 24'h0},
      '{ROW_SAMPLE, IDX_NONE, 24'h400000, 3'd1, NO_CHECK, 24'h0},
      '{ROW_SAMPLE, IDX_NONE, 24'h000000, 3'd0, NO_CHECK, 24'h0},
      // history must survive a write to an unused index
      '{ROW_CSR, CSR_SPARE_LO, 24'hFFFFFF, 3'd0, NO_CHECK, 24'h0},
      '{ROW_SAMPLE, IDX_NONE, 24'h000000, 3'd0, NO_CHECK, 24'h0},
      '{ROW_SAMPLE, IDX_NONE, 24'h000000, 3'd1, NO_CHECK, 24'h0},
      '{ROW_SAMPLE, IDX_NONE, SMIN,       3'd0, NO_CHECK, 24'h0}
   };

   biquad_iir_filter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void clear_history();
      for (int c = 0; c < CH_COUNT; c++) begin
         hist_x1[c] = '0;
         hist_x2[c] = '0;
         hist_y1[c] = '0;
         hist_y2[c] = '0;
      end
   endfunction

   // y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, round half up, saturate
   function automatic logic [23:0] filter_sample(logic [23:0] s, logic [2:0] c);
      longint             acc;
      longint             q;
      logic signed [23:0] x;
      logic signed [23:0] y;
      x = s;
      y = '0;
      if (c < CH_COUNT) begin
         acc = longint'(gain_val[CSR_FF_GAIN_0]) * longint'(x)
             + longint'(gain_val[CSR_FF_GAIN_1]) * longint'(hist_x1[c])
             + longint'(gain_val[CSR_FF_GAIN_2]) * longint'(hist_x2[c])
             - longint'(gain_val[CSR_FB_GAIN_1]) * longint'(hist_y1[c])
             - longint'(gain_val[CSR_FB_GAIN_2]) * longint'(hist_y2[c]);
         q = (acc + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
         if (q > SAT_HI) begin
            y = SMAX;
         end else if (q < SAT_LO) begin
            y = SMIN;
         end else begin
            y = q[23:0];
         end
         hist_x2[c] = hist_x1[c];
         hist_x1[c] = x;
         hist_y2[c] = hist_y1[c];
         hist_y1[c] = y;
      end
      return y;
   endfunction

   function automatic int pick_gap(bit busy);
      int r;
      r = $urandom_range(0, 99);
      if (!busy || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic drive_item(logic [23:0] s, logic [2:0] c, int gap,
                             logic typed, logic [23:0] want);
      filt_out_type e;
      logic [23:0]  y;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      y = filter_sample(s, c);
      e.sample = typed ? want : y;
      e.chan   = c;
      pending_out.push_back(e);
   endtask

   task automatic drain_out();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [23:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      if (idx <= CSR_FB_GAIN_2) begin
         gain_val[idx] = v;
         clear_history();
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // response side: random backpressure plus one long hold-off
   initial begin
      int           stall;
      int           cyc;
      bit           rx_busy;
      bit           hold_done;
      filt_out_type e;
      stall      = 0;
      cyc        = 0;
      rx_busy    = 1'b1;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_out.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_tdata, '0);
            end else begin
               e = pending_out.pop_front();
               if (rsp_tdata != e.sample)
                  report_mismatch("sample_out", rsp_tdata, e.sample);
               if (rsp_tuser != e.chan)
                  report_mismatch("channel_out", 24'(rsp_tuser), 24'(e.chan));
            end
         end
         @(negedge clock);
         cyc++;
         if (cyc % 128 == 0) rx_busy = ($urandom_range(0, 3) != 0);
         if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            stall     = HOLD_CYCLES;
         end
         if (stall == 0) stall = pick_gap(rx_busy);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
            idle = 0;
         else
            idle++;
      end
      $display("biquad_iir_filter verification failed");
      $finish;
   end

   initial begin
      int          i;
      int          p;
      int          n;
      int          k;
      int          mode;
      bit          tx_busy;
      logic [31:0] r;
      logic [23:0] s;
      logic [23:0] g;
      logic [2:0]  c;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      errors       = 0;
      results_seen = 0;
      c            = '0;
      gain_val[CSR_FF_GAIN_0] = FF_GAIN_0_RESET;
      gain_val[CSR_FF_GAIN_1] = '0;
      gain_val[CSR_FF_GAIN_2] = '0;
      gain_val[CSR_FB_GAIN_1] = '0;
      gain_val[CSR_FB_GAIN_2] = '0;
      clear_history();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIR; i++) begin
         if (plan[i].kind == ROW_CSR) begin
            drain_out();
            write_csr(plan[i].idx, plan[i].val);
         end else begin
            drive_item(plan[i].val, plan[i].chan, pick_gap(1'b1),
                       plan[i].typed, plan[i].want);
         end
      end

      for (p = 0; p < PHASES; p++) begin
         drain_out();
         mode = p % 4;
         for (k = CSR_FF_GAIN_0; k <= CSR_FB_GAIN_2; k++) begin
            r = $urandom;
            case (mode)
               0: g = r[23:0];
               1: g = {{4{r[19]}}, r[19:0]};
               2: begin
                  case ($urandom_range(0, 2))
                     0: g = SMAX;
                     1: g = SMIN;
                     default: g = '0;
                  endcase
               end
               default: begin
                  g = (k == CSR_FF_GAIN_0) ? FF_GAIN_0_RESET : {{5{r[18]}}, r[18:0]};
               end
            endcase
            write_csr(k[CSR_INDEX_BITS-1:0], g);
         end
         tx_busy = (p != 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               drain_out();
               write_csr(3'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), 24'($urandom));
            end else if ($urandom_range(0, 149) == 0) begin
               drain_out();
            end
            r = $urandom;
            case ($urandom_range(0, 9))
               0: begin
                  case ($urandom_range(0, 4))
                     0: s = SMAX;
                     1: s = SMIN;
                     2: s = 24'h000001;
                     3: s = 24'hFFFFFF;
                     default: s = '0;
                  endcase
               end
               1, 2: s = {{13{r[10]}}, r[10:0]};
               default: s = r[23:0];
            endcase
            if ($urandom_range(0, 1) == 0) c = 3'($urandom_range(0, CH_COUNT - 1));
            drive_item(s, c, pick_gap(tx_busy), NO_CHECK, '0);
         end
      end

      drain_out();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("biquad_iir_filter verification clean");
      end else begin
         $display("biquad_iir_filter verification failed");
      end
      $finish;
   end

endmodule
